// ===== rtl/core/ctps_pkg.sv =====
package ctps_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;

    localparam int CHAR_W = 8;
    localparam int CTX_W  = 2;
    localparam int SLOT_W = 6;
    localparam int PROB_W = 16;
    localparam int KEY_W  = CHAR_W + CTX_W + 2 * CHAR_W;
    // stored word: valid, key, probability
    localparam int MEM_W  = 1 + KEY_W + PROB_W;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_CHAR = 1'b1;

    localparam logic [CTX_W-1:0] CTX_NONE = 2'd0;
    localparam logic [CTX_W-1:0] CTX_ONE  = 2'd1;
    localparam logic [CTX_W-1:0] CTX_TWO  = 2'd2;

    typedef logic [KEY_W-1:0] key_t;

    typedef struct packed {
        logic              kind;
        logic [SLOT_W-1:0] slot;
        logic [CHAR_W-1:0] entry_char;
        logic [CTX_W-1:0]  entry_context_len;
        logic [CHAR_W-1:0] entry_older;
        logic [CHAR_W-1:0] entry_newer;
        logic [PROB_W-1:0] entry_prob;
        logic [CHAR_W-1:0] word_char;
        logic              word_last;
    } cmd_t;

    typedef struct packed {
        logic [PROB_W-1:0] step_prob;
        logic              found;
        logic [PROB_W-1:0] running_product;
        logic              final_res;
    } res_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MUL
    } state_t;

    typedef struct packed {
        logic clear_we;
        logic rd_en;
        logic cmp_en;
        logic finish;
    } ctrl_t;

    // context chars outside the context length are forced to zero
    function automatic key_t make_key(
        input logic [CHAR_W-1:0] ch,
        input logic [CTX_W-1:0]  ctx,
        input logic [CHAR_W-1:0] older,
        input logic [CHAR_W-1:0] newer
    );
        logic [CHAR_W-1:0] o;
        logic [CHAR_W-1:0] n;
        begin
            o = older;
            n = newer;
            if (ctx == CTX_NONE)
            begin
                o = '0;
                n = '0;
            end
            else if (ctx == CTX_ONE)
            begin
                o = '0;
            end
            return {ch, ctx, o, n};
        end
    endfunction

endpackage

// ===== rtl/core/char_trigram_probability_scorer.sv =====
// load word: taken while idle and written to its slot, no result
// char word: result strobed on done after the scan and the multiply step, busy till then;
// no new char is taken before done, as the scan does one table read per slot
// followed by the multiply step; the receiver cannot stall, done lasts one cycle
// reset: a clearing pass over every slot with busy high, then word state is zero
module char_trigram_probability_scorer #(
    parameter int TABLE_ENTRIES = ctps_pkg::TABLE_ENTRIES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  ctps_pkg::cmd_t cmd,
    output logic           done,
    output ctps_pkg::res_t res
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int SW = AW + ctps_pkg::SLOT_W;

    ctps_pkg::ctrl_t            ctrl;
    logic [AW-1:0]              seq_addr;
    logic                       accept;

    logic                       we;
    logic [AW-1:0]              waddr;
    logic [ctps_pkg::MEM_W-1:0] wdata;
    logic [ctps_pkg::MEM_W-1:0] rdata;
    logic [SW-1:0]              slot_ext;
    logic                       slot_ok;

    ctps_pkg::key_t             key_reg;
    logic                       last_reg;
    logic                       hit_reg;
    logic [ctps_pkg::PROB_W-1:0] prob_reg;

    logic [ctps_pkg::CHAR_W-1:0] prior_reg;
    logic [ctps_pkg::CHAR_W-1:0] pprior_reg;
    logic [ctps_pkg::CTX_W-1:0]  pos_reg;
    logic [ctps_pkg::PROB_W-1:0] product_reg;
    logic [ctps_pkg::PROB_W-1:0] product_next;
    logic [2*ctps_pkg::PROB_W-1:0] mul;

    logic                       rd_valid;
    ctps_pkg::key_t             rd_key;
    logic [ctps_pkg::PROB_W-1:0] rd_prob;
    logic                       match;

    logic                       done_reg;
    ctps_pkg::res_t             res_reg;

    ctps_seq #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_seq (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .kind (cmd.kind),
        .busy (busy),
        .addr (seq_addr),
        .ctrl (ctrl)
    );

    assign accept   = start && !busy;
    assign slot_ext = SW'(cmd.slot);
    assign slot_ok  = slot_ext < SW'(TABLE_ENTRIES);

    always_comb
    begin
        if (ctrl.clear_we)
        begin
            we    = 1'b1;
            waddr = seq_addr;
            wdata = '0;
        end
        else
        begin
            we    = accept && cmd.kind == ctps_pkg::KIND_LOAD && slot_ok;
            waddr = slot_ext[AW-1:0];
            wdata = {1'b1,
                     ctps_pkg::make_key(cmd.entry_char, cmd.entry_context_len,
                                        cmd.entry_older, cmd.entry_newer),
                     cmd.entry_prob};
        end
    end

    ctps_ram #(
        .WIDTH(ctps_pkg::MEM_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (ctrl.rd_en),
        .raddr(seq_addr),
        .rdata(rdata)
    );

    assign {rd_valid, rd_key, rd_prob} = rdata;
    assign match = rd_valid && rd_key == key_reg;

    // scan runs upwards, so the highest matching slot is the one kept
    always_ff @(posedge clk)
    begin
        if (accept && cmd.kind == ctps_pkg::KIND_CHAR)
        begin
            key_reg  <= ctps_pkg::make_key(cmd.word_char, pos_reg, pprior_reg, prior_reg);
            last_reg <= cmd.word_last;
            hit_reg  <= 1'b0;
            prob_reg <= '0;
        end
        else if (ctrl.cmp_en && match)
        begin
            hit_reg  <= 1'b1;
            prob_reg <= rd_prob;
        end
    end

    assign mul = (2*ctps_pkg::PROB_W)'(product_reg) * (2*ctps_pkg::PROB_W)'(prob_reg);

    always_comb
    begin
        if (pos_reg == ctps_pkg::CTX_NONE)
        begin
            product_next = prob_reg;
        end
        else
        begin
            product_next = mul[2*ctps_pkg::PROB_W-1:ctps_pkg::PROB_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_reg   <= '0;
            pprior_reg  <= '0;
            pos_reg     <= ctps_pkg::CTX_NONE;
            product_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.finish;
            if (ctrl.finish)
            begin
                if (last_reg)
                begin
                    prior_reg   <= '0;
                    pprior_reg  <= '0;
                    pos_reg     <= ctps_pkg::CTX_NONE;
                    product_reg <= '0;
                end
                else
                begin
                    pprior_reg  <= prior_reg;
                    prior_reg   <= key_reg[ctps_pkg::KEY_W-1 -: ctps_pkg::CHAR_W];
                    product_reg <= product_next;
                    if (pos_reg != ctps_pkg::CTX_TWO)
                    begin
                        pos_reg <= pos_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.finish)
        begin
            res_reg.step_prob       <= prob_reg;
            res_reg.found           <= hit_reg;
            res_reg.running_product <= product_next;
            res_reg.final_res       <= last_reg;
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// ===== rtl/core/ctps_ram.sv =====
module ctps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/ctps_seq.sv =====
module ctps_seq #(
    parameter int TABLE_ENTRIES = ctps_pkg::TABLE_ENTRIES_DEF,
    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
    localparam int CW = $clog2(TABLE_ENTRIES + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                kind,
    output logic                busy,
    output logic [AW-1:0]       addr,
    output ctps_pkg::ctrl_t     ctrl
);

    localparam logic [CW-1:0] CNT_LAST = CW'(TABLE_ENTRIES - 1);
    localparam logic [CW-1:0] CNT_END  = CW'(TABLE_ENTRIES);

    ctps_pkg::state_t state_reg;
    ctps_pkg::state_t state_next;
    logic [CW-1:0]    cnt_reg;
    logic [CW-1:0]    cnt_next;
    logic             rdv_reg;
    logic             rdv_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ctps_pkg::ST_CLEAR;
            cnt_reg   <= '0;
            rdv_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rdv_reg   <= rdv_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ctps_pkg::ST_CLEAR:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ctps_pkg::ST_IDLE;
                end
            end
            ctps_pkg::ST_IDLE:
            begin
                if (start && kind == ctps_pkg::KIND_CHAR)
                begin
                    state_next = ctps_pkg::ST_SCAN;
                end
            end
            ctps_pkg::ST_SCAN:
            begin
                if (cnt_reg == CNT_END)
                begin
                    state_next = ctps_pkg::ST_MUL;
                end
            end
            ctps_pkg::ST_MUL:
            begin
                state_next = ctps_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ctps_pkg::ST_IDLE;
            end
        endcase
    end

    // slot counter, shared by the clearing pass and the scan
    always_comb
    begin
        cnt_next = cnt_reg;
        unique case (state_reg)
            ctps_pkg::ST_CLEAR:
            begin
                cnt_next = (cnt_reg == CNT_LAST) ? '0 : cnt_reg + 1'b1;
            end
            ctps_pkg::ST_SCAN:
            begin
                cnt_next = (cnt_reg == CNT_END) ? '0 : cnt_reg + 1'b1;
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        ctrl     = '0;
        busy     = 1'b1;
        rdv_next = 1'b0;
        unique case (state_reg)
            ctps_pkg::ST_CLEAR:
            begin
                ctrl.clear_we = 1'b1;
            end
            ctps_pkg::ST_IDLE:
            begin
                busy = 1'b0;
            end
            ctps_pkg::ST_SCAN:
            begin
                ctrl.rd_en  = (cnt_reg != CNT_END);
                ctrl.cmp_en = rdv_reg;
                rdv_next    = (cnt_reg != CNT_END);
            end
            ctps_pkg::ST_MUL:
            begin
                ctrl.finish = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    assign addr = cnt_reg[AW-1:0];

endmodule
